/* rtl/nearest_point_in_ellipsoid_assert.svh */
// Assertion macros used by the top-level RTL file.
`ifndef NEAREST_POINT_IN_ELLIPSOID_ASSERT_SVH
`define NEAREST_POINT_IN_ELLIPSOID_ASSERT_SVH
`ifndef SYNTHESIS
`define NPE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define NPE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define NPE_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define NPE_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/npe_pkg.sv */
`default_nettype none
package npe_pkg;
    localparam int MAX_POINTS   = 1024;
    localparam int IDX_W        = $clog2(MAX_POINTS);
    localparam int CNT_W        = $clog2(MAX_POINTS + 1);
    localparam int COORD_W      = 16;
    localparam int SCALE_W      = 16;
    localparam int SUM_W        = 34;
    localparam int DRAIN_CYCLES = 16;
    localparam int DRAIN_W      = $clog2(DRAIN_CYCLES + 1);

    localparam logic [1:0] ACT_CLEAR  = 2'd0;
    localparam logic [1:0] ACT_APPEND = 2'd1;
    localparam logic [1:0] ACT_QUERY  = 2'd2;

    localparam logic [1:0] REG_SCALE_X = 2'd0;
    localparam logic [1:0] REG_SCALE_Y = 2'd1;
    localparam logic [1:0] REG_SCALE_Z = 2'd2;

    localparam logic [SUM_W-1:0]   SUM_ONE     = SUM_W'(64'h1_0000_0000);
    localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(1280);

    typedef struct packed {
        logic [1:0]                action;
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
        logic signed [COORD_W-1:0] coord_z;
    } t_npe_req;

    typedef struct packed {
        logic       found;
        logic [9:0] match_index;
    } t_npe_resp;

    // One candidate point travelling down the cell row.
    typedef struct packed {
        logic               valid;
        logic [IDX_W-1:0]   idx;
        logic [COORD_W-1:0] c0;
        logic [COORD_W-1:0] c1;
        logic [COORD_W-1:0] c2;
        logic [SUM_W-1:0]   sum;
        logic               skip;
    } t_npe_flow;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN
    } t_npe_state;
endpackage
`default_nettype wire

/* rtl/nearest_point_in_ellipsoid.sv */
`default_nettype none
// Brute-force nearest point search over a store of up to MAX_POINTS 3D points.
// A request is taken when i_start is high and o_busy is low. Its action field
// clears the store, appends one point, or queries with the given coordinates.
// Clear and append finish in the cycle they are taken and give no result.
// A query walks the stored points one per cycle through a dual-port RAM into
// a row of three identical cells, one per axis, each adding its scaled square
// to the running sum; a tracker keeps the point with the smallest sum below 1.0.
// A query keeps o_busy high through one RAM read per point and then a drain
// of the cell row and tracker. At the end o_valid pulses for one cycle with
// o_resp; the receiver cannot stall it.
// Scale registers are written through i_cfg_we / i_cfg_index / i_cfg_data at
// any edge and should only change while the block is idle.
// Reset empties the store and sets all scales to 5.0; RAM contents are left
// as they are, since a query never reads past the point count.
`include "nearest_point_in_ellipsoid_assert.svh"
module nearest_point_in_ellipsoid import npe_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire t_npe_req           i_req,
    output logic                    o_busy,
    output logic                    o_valid,
    output t_npe_resp               o_resp,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [SCALE_W-1:0] i_cfg_data
);
    t_npe_state         r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CNT_W-1:0]   r_addr, n_addr;
    logic [DRAIN_W-1:0] r_drain, n_drain;
    logic [SCALE_W-1:0] r_scale_x, r_scale_y, r_scale_z;
    logic               r_rd_valid, n_rd_valid;
    logic [IDX_W-1:0]   r_rd_idx;
    logic [SUM_W-1:0]   r_best;
    logic               r_found;
    logic [IDX_W-1:0]   r_idx;
    logic               r_out_valid, n_out_valid;
    logic               w_accept, w_load, w_we, w_issue;
    logic [47:0]        w_rdata;
    t_npe_flow          w_f0, w_f1, w_f2, w_f3;

    assign w_accept = i_start && (r_state == ST_IDLE);
    assign w_load   = w_accept && (i_req.action == ACT_QUERY);
    assign w_we     = w_accept && (i_req.action == ACT_APPEND)
                      && (r_count < CNT_W'(MAX_POINTS));
    assign w_issue  = (r_state == ST_SCAN) && (r_addr < r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale_x <= SCALE_RESET;
            r_scale_y <= SCALE_RESET;
            r_scale_z <= SCALE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_SCALE_X: r_scale_x <= i_cfg_data;
                REG_SCALE_Y: r_scale_y <= i_cfg_data;
                REG_SCALE_Z: r_scale_z <= i_cfg_data;
                default: ;
            endcase
        end
    end

    npe_ram #(.WIDTH(48), .DEPTH(MAX_POINTS)) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata ({i_req.coord_x, i_req.coord_y, i_req.coord_z}),
        .i_raddr (r_addr[IDX_W-1:0]),
        .o_rdata (w_rdata)
    );

    always_comb begin
        w_f0       = '0;
        w_f0.valid = r_rd_valid;
        w_f0.idx   = r_rd_idx;
        w_f0.c0    = w_rdata[47:32];
        w_f0.c1    = w_rdata[31:16];
        w_f0.c2    = w_rdata[15:0];
    end

    npe_cell u_cell_x (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_load(w_load),
        .i_query(i_req.coord_x), .i_scale(r_scale_x), .i_flow(w_f0), .o_flow(w_f1));
    npe_cell u_cell_y (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_load(w_load),
        .i_query(i_req.coord_y), .i_scale(r_scale_y), .i_flow(w_f1), .o_flow(w_f2));
    npe_cell u_cell_z (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_load(w_load),
        .i_query(i_req.coord_z), .i_scale(r_scale_z), .i_flow(w_f2), .o_flow(w_f3));

    // Strictly-less compare keeps the earliest index on ties.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_best  <= SUM_ONE;
            r_found <= 1'b0;
            r_idx   <= '0;
        end else if (w_f3.valid && !w_f3.skip && (w_f3.sum < r_best)) begin
            r_best  <= w_f3.sum;
            r_found <= 1'b1;
            r_idx   <= w_f3.idx;
        end
        r_rd_idx <= r_addr[IDX_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_addr      <= '0;
            r_drain     <= '0;
            r_rd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_addr      <= n_addr;
            r_drain     <= n_drain;
            r_rd_valid  <= n_rd_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_addr      = r_addr;
        n_drain     = r_drain;
        n_rd_valid  = w_issue;
        n_out_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    unique case (i_req.action)
                        ACT_CLEAR:  n_count = '0;
                        ACT_APPEND: begin
                            if (w_we) begin
                                n_count = r_count + 1'b1;
                            end
                        end
                        ACT_QUERY: begin
                            n_addr  = '0;
                            n_state = ST_SCAN;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCAN: begin
                if (w_issue) begin
                    n_addr = r_addr + 1'b1;
                end else begin
                    n_drain = '0;
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (r_drain == DRAIN_W'(DRAIN_CYCLES - 1)) begin
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end else begin
                    n_drain = r_drain + 1'b1;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_busy             = (r_state != ST_IDLE);
    assign o_valid            = r_out_valid;
    assign o_resp.found       = r_found;
    assign o_resp.match_index = 10'(r_idx);

    `NPE_ASSERT_IMP(a_no_idx_when_miss, i_clk, i_rst_n, o_valid && !o_resp.found,
        o_resp.match_index == 10'd0)
    `NPE_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(MAX_POINTS))
    `NPE_ASSERT_IMP(a_scan_addr, i_clk, i_rst_n, r_state == ST_SCAN, r_addr <= r_count)
    `NPE_ASSERT_IMP(a_result_idle, i_clk, i_rst_n, o_valid, r_state == ST_IDLE)
    `NPE_ASSERT_NXT(a_read_follows_scan, i_clk, i_rst_n, w_issue, r_rd_valid)
endmodule
`default_nettype wire

/* rtl/npe_ram.sv */
`default_nettype none
module npe_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

/* rtl/npe_cell.sv */
`default_nettype none
module npe_cell import npe_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_load,
    input  wire logic [COORD_W-1:0] i_query,
    input  wire logic [SCALE_W-1:0] i_scale,
    input  wire t_npe_flow          i_flow,
    output t_npe_flow               o_flow
);
    logic [COORD_W-1:0]       r_query;
    t_npe_flow                r_f1, r_f2, r_f3, r_f4, n_f4;
    logic [COORD_W:0]         r_abs;
    logic [COORD_W+SCALE_W:0] r_prod;
    logic [31:0]              r_sq;
    logic                     r_over;
    logic [COORD_W:0]         w_diff;
    logic [COORD_W:0]         w_abs;

    assign w_diff = {i_flow.c0[COORD_W-1], i_flow.c0} - {r_query[COORD_W-1], r_query};
    assign w_abs  = w_diff[COORD_W] ? (~w_diff + 1'b1) : w_diff;

    always_comb begin
        // Rotate the coordinates so the next cell sees its own axis in c0.
        n_f4      = r_f3;
        n_f4.c0   = r_f3.c1;
        n_f4.c1   = r_f3.c2;
        n_f4.c2   = r_f3.c0;
        n_f4.sum  = r_f3.sum + {2'b00, r_sq};
        n_f4.skip = r_f3.skip | r_over;
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_query <= i_query;
        end
        r_abs  <= w_abs;
        r_prod <= r_abs * {1'b0, i_scale};
        r_over <= |r_prod[COORD_W+SCALE_W:16];
        r_sq   <= r_prod[15:0] * r_prod[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1 <= '0;
            r_f2 <= '0;
            r_f3 <= '0;
            r_f4 <= '0;
        end else begin
            r_f1 <= i_flow;
            r_f2 <= r_f1;
            r_f3 <= r_f2;
            r_f4 <= n_f4;
        end
    end

    assign o_flow = r_f4;
endmodule
`default_nettype wire
